/* design/ufem_pkg.sv */
// Shared constants and types for the union-find edge merger.
// No dependencies; compiled first.
`default_nettype none

package ufem_pkg;

    localparam int NODE_W    = 16;            // node index field width
    localparam int CNT_W     = 17;            // node_count register width
    localparam int RANK_W    = 5;             // stored rank width
    localparam int TABLE_MAX = 65536;         // entries reachable by a 16-bit index
    localparam int NODES_DEF = 65536;

    localparam logic [CNT_W-1:0]  NODE_CNT_RST = 17'h10000;
    localparam logic [RANK_W-1:0] RANK_MAX     = 5'd31;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [RANK_W-1:0] t_rank;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FIND_A = 6'b000010,
        ST_FIND_B = 6'b000100,
        ST_LINK   = 6'b001000,
        ST_BUMP   = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

endpackage

`default_nettype wire

/* design/ufem_if.sv */
// Request channels of the union-find edge merger: edge in, result out, config write.
// Depends on ufem_pkg.
`default_nettype none

interface ufem_edge_if;
    import ufem_pkg::*;
    logic  valid;
    logic  ready;
    t_node node_a;
    t_node node_b;
    modport source (output valid, node_a, node_b, input ready);
    modport sink   (input valid, node_a, node_b, output ready);
endinterface

interface ufem_result_if;
    import ufem_pkg::*;
    logic  valid;
    logic  ready;
    logic  joined;
    t_node merged_root;
    t_node edges_taken;
    logic  tree_complete;
    modport source (output valid, joined, merged_root, edges_taken, tree_complete,
                    input ready);
    modport sink   (input valid, joined, merged_root, edges_taken, tree_complete,
                    output ready);
endinterface

interface ufem_cfg_if;
    import ufem_pkg::*;
    logic   valid;
    logic   ready;
    t_count node_count;
    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

`default_nettype wire

/* design/ufem_table.sv */
// Parent/rank table: one synchronous RAM, one write and one read port, with the
// post-reset sweep that loads identity links and zero ranks. Depends on ufem_pkg.
`default_nettype none

module ufem_table #(
    parameter  int DEPTH = ufem_pkg::NODES_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire logic [IDX_W-1:0]   i_rd_addr,
    output      logic [IDX_W-1:0]   o_rd_parent,
    output      ufem_pkg::t_rank    o_rd_rank,
    input  wire logic               i_wr_en,
    input  wire logic [IDX_W-1:0]   i_wr_addr,
    input  wire logic [IDX_W-1:0]   i_wr_parent,
    input  wire ufem_pkg::t_rank    i_wr_rank,
    output      logic               o_clr_busy
);
    import ufem_pkg::*;

    localparam int WORD_W = RANK_W + IDX_W;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [IDX_W-1:0]  r_clr_idx;

    logic              n_wr_en;
    logic [IDX_W-1:0]  n_wr_addr;
    logic [WORD_W-1:0] n_wr_data;

    // sweep owns the write port until every entry is loaded
    always_comb begin
        if (r_clr_busy) begin
            n_wr_en   = 1'b1;
            n_wr_addr = r_clr_idx;
            n_wr_data = {t_rank'(0), r_clr_idx};
        end else begin
            n_wr_en   = i_wr_en;
            n_wr_addr = i_wr_addr;
            n_wr_data = {i_wr_rank, i_wr_parent};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == IDX_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_rd_parent = r_rd_data[IDX_W-1:0];
    assign o_rd_rank   = r_rd_data[WORD_W-1:IDX_W];
    assign o_clr_busy  = r_clr_busy;

endmodule

`default_nettype wire

/* design/ufem_ctrl.sv */
// Find/union sequencer: walks parent links through the table RAM, links roots by
// rank, keeps the tree edge count and the result register. Depends on ufem_pkg, ufem_if.
`default_nettype none

module ufem_ctrl #(
    parameter  int DEPTH = ufem_pkg::NODES_DEF,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ufem_edge_if.sink               i_edge,
    ufem_result_if.source           o_result,
    ufem_cfg_if.sink                i_cfg,
    input  wire logic               i_clr_busy,
    output      logic               o_rd_en,
    output      logic [IDX_W-1:0]   o_rd_addr,
    input  wire logic [IDX_W-1:0]   i_rd_parent,
    input  wire ufem_pkg::t_rank    i_rd_rank,
    output      logic               o_wr_en,
    output      logic [IDX_W-1:0]   o_wr_addr,
    output      logic [IDX_W-1:0]   o_wr_parent,
    output      ufem_pkg::t_rank    o_wr_rank
);
    import ufem_pkg::*;

    localparam t_count DEPTH_CNT = CNT_W'(DEPTH);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cur, r_b, r_ra, r_hi, r_lo, r_root;
    t_rank            r_rank_a, r_rank_hi, r_rank_lo;
    logic             r_bump, r_joined;
    t_node            r_edges;
    t_count           r_node_count;
    logic             r_out_valid;

    logic             edge_acc;
    logic             edge_oob;
    logic             found;
    logic             complete;
    logic             load_out;
    logic             b_higher;
    logic             do_join;

    assign edge_acc = i_edge.valid && i_edge.ready;
    assign edge_oob = ({1'b0, i_edge.node_a} >= DEPTH_CNT) ||
                      ({1'b0, i_edge.node_b} >= DEPTH_CNT);
    assign found    = (i_rd_parent == r_cur);
    assign complete = (r_node_count != '0) && (({1'b0, r_edges} + 1'b1) == r_node_count);
    assign b_higher = (r_rank_a < i_rd_rank);
    assign do_join  = (r_ra != r_cur) && !complete;

    always_comb begin
        n_state      = r_state;
        i_edge.ready = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_cur;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_lo;
        o_wr_parent  = r_hi;
        o_wr_rank    = r_rank_lo;
        load_out     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_edge.ready = !i_clr_busy;
                if (i_edge.valid && !i_clr_busy) begin
                    if (edge_oob) begin
                        n_state = ST_DONE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = i_edge.node_a[IDX_W-1:0];
                        n_state   = ST_FIND_A;
                    end
                end
            end
            ST_FIND_A: begin
                o_rd_en = 1'b1;
                if (found) begin
                    o_rd_addr = r_b;
                    n_state   = ST_FIND_B;
                end else begin
                    o_rd_addr = i_rd_parent;
                end
            end
            ST_FIND_B: begin
                if (found) begin
                    n_state = do_join ? ST_LINK : ST_DONE;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = i_rd_parent;
                end
            end
            ST_LINK: begin
                o_wr_en = 1'b1;
                n_state = r_bump ? ST_BUMP : ST_DONE;
            end
            ST_BUMP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_hi;
                o_wr_rank = t_rank'(r_rank_hi + 1'b1);
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_edges      <= '0;
            r_node_count <= NODE_CNT_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_node_count <= i_cfg.node_count;
            end
            if (r_state == ST_LINK && r_edges != '1) begin
                r_edges <= r_edges + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and link datapath
    always_ff @(posedge i_clk) begin
        if (o_rd_en) begin
            r_cur <= o_rd_addr;
        end
        if (edge_acc) begin
            r_b      <= i_edge.node_b[IDX_W-1:0];
            r_joined <= 1'b0;
            r_root   <= '0;
        end
        if (r_state == ST_FIND_A && found) begin
            r_ra     <= r_cur;
            r_rank_a <= i_rd_rank;
        end
        if (r_state == ST_FIND_B && found) begin
            // equal ranks: end node's root goes under the start node's root
            if (b_higher) begin
                r_hi      <= r_cur;
                r_lo      <= r_ra;
                r_rank_hi <= i_rd_rank;
                r_rank_lo <= r_rank_a;
            end else begin
                r_hi      <= r_ra;
                r_lo      <= r_cur;
                r_rank_hi <= r_rank_a;
                r_rank_lo <= i_rd_rank;
            end
            r_bump   <= (r_rank_a == i_rd_rank) && (r_rank_a != RANK_MAX);
            r_joined <= do_join;
            r_root   <= (do_join && b_higher) ? r_cur : r_ra;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_result.joined        <= r_joined;
            o_result.merged_root   <= NODE_W'(r_root);
            o_result.edges_taken   <= r_edges;
            o_result.tree_complete <= complete;
        end
    end

    assign o_result.valid = r_out_valid;
    assign i_cfg.ready    = 1'b1;

`ifndef SYNTHESIS
    a_acc_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        edge_acc |-> !i_clr_busy)
        else $error("edge request taken during table sweep");
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> !i_clr_busy)
        else $error("table write during sweep");
    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LINK |-> r_lo != r_hi)
        else $error("root linked to itself");
    a_bump_after_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BUMP |-> $past(r_state) == ST_LINK)
        else $error("rank raise without link");
    a_edges_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_edges >= $past(r_edges))
        else $error("tree edge count went down");
`endif

endmodule

`default_nettype wire

/* design/union_find_edge_merger_top.sv */
// Union-find edge merger (Kruskal merge core, union by rank, no path compression).
// Per edge: find both roots, link them on a merge, raise the kept root's rank on equal ranks,
//   then register the result; parent hops to each root are at most 16 for 65536 nodes.
// Throughput: one edge at a time; each hop is one read of the table RAM's read port.
// Reset: synchronous active low; then a sweep loads all min(NODES, 65536) table entries
//   (no edge taken meanwhile, config writes still taken); node_count resets to 65536.
`default_nettype none

module union_find_edge_merger_top #(
    parameter int NODES = ufem_pkg::NODES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ufem_edge_if.sink     i_edge,
    ufem_result_if.source o_result,
    ufem_cfg_if.sink      i_cfg
);
    import ufem_pkg::*;

    localparam int DEPTH = (NODES > TABLE_MAX) ? TABLE_MAX : NODES;
    localparam int IDX_W = $clog2(DEPTH);

    logic             clr_busy;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_parent;
    t_rank            rd_rank;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_parent;
    t_rank            wr_rank;

    ufem_table #(.DEPTH(DEPTH)) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_parent (rd_parent),
        .o_rd_rank   (rd_rank),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_parent (wr_parent),
        .i_wr_rank   (wr_rank),
        .o_clr_busy  (clr_busy)
    );

    ufem_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_edge      (i_edge),
        .o_result    (o_result),
        .i_cfg       (i_cfg),
        .i_clr_busy  (clr_busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_parent (rd_parent),
        .i_rd_rank   (rd_rank),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_parent (wr_parent),
        .o_wr_rank   (wr_rank)
    );

endmodule

`default_nettype wire
